### rtl/core/aic_pkg.sv
package aic_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned KindWidth = 8;

   typedef logic [KindWidth-1:0] kind_type;

   localparam logic [3:0] CondNever  = 4'b1111;
   localparam logic [3:0] CondAlways = 4'b1110;
   localparam logic [3:0] CpSingle   = 4'b1010;
   localparam logic [3:0] CpDouble   = 4'b1011;
   localparam logic [7:0] CpyTop     = 8'b00011010;
   localparam logic [4:0] Misc10     = 5'b10010;

   localparam kind_type K_UNDEF = 8'd0;
   localparam kind_type K_MRS = 8'd1, K_MSR_REG = 8'd2, K_CLZ = 8'd3, K_BX = 8'd4;
   localparam kind_type K_BLX2 = 8'd5, K_QADD = 8'd6, K_QSUB = 8'd7, K_QDADD = 8'd8;
   localparam kind_type K_QDSUB = 8'd9, K_BKPT = 8'd10, K_SMLAXY = 8'd11;
   localparam kind_type K_SMLALXY = 8'd12, K_SMLAWY = 8'd13, K_SMULXY = 8'd14;
   localparam kind_type K_SMULWY = 8'd15, K_STRD = 8'd16, K_MUL = 8'd17, K_MLA = 8'd18;
   localparam kind_type K_UMAAL = 8'd19, K_UMULL = 8'd20, K_UMLAL = 8'd21;
   localparam kind_type K_SMULL = 8'd22, K_SMLAL = 8'd23, K_SWP = 8'd24, K_SWPB = 8'd25;
   localparam kind_type K_LDREX = 8'd26, K_STREX = 8'd27, K_LDRH = 8'd28;
   localparam kind_type K_STRH = 8'd29, K_LDRSB = 8'd30, K_LDRD = 8'd31;
   localparam kind_type K_LDRSH = 8'd32, K_PLD = 8'd33, K_CPS = 8'd34, K_RFE = 8'd35;
   localparam kind_type K_SRS = 8'd36, K_BLX1 = 8'd37, K_LDC2 = 8'd38, K_STC2 = 8'd39;
   localparam kind_type K_CDP2 = 8'd40, K_MRC2 = 8'd41, K_MCR2 = 8'd42;
   localparam kind_type K_AND = 8'd43;
   localparam kind_type K_TST = 8'd51, K_TSTP = 8'd52;
   localparam kind_type K_ORR = 8'd59;
   localparam kind_type K_STR = 8'd63, K_LDR = 8'd64, K_STRB = 8'd65, K_LDRB = 8'd66;
   localparam kind_type K_STRT = 8'd67, K_LDRT = 8'd68, K_STRBT = 8'd69;
   localparam kind_type K_LDRBT = 8'd70;
   localparam kind_type K_FCMPEZS = 8'd71, K_FCMPES = 8'd72, K_FABSS = 8'd73;
   localparam kind_type K_FSITOS = 8'd74, K_FTOSIS = 8'd75, K_FSQRTS = 8'd76;
   localparam kind_type K_FTOUIS = 8'd77, K_FADDS = 8'd78, K_FCMPS = 8'd79;
   localparam kind_type K_FUITOS = 8'd80, K_FCMPZS = 8'd81, K_FCPYS = 8'd82;
   localparam kind_type K_FNEGS = 8'd83, K_FDIVS = 8'd84, K_FMACS = 8'd85;
   localparam kind_type K_FNMACS = 8'd86, K_FNMSCS = 8'd87, K_FNMULS = 8'd88;
   localparam kind_type K_FMRS = 8'd89, K_FMSTAT = 8'd90, K_FMRX = 8'd91;
   localparam kind_type K_FMSCS = 8'd92, K_FMSR = 8'd93, K_FMULS = 8'd94;
   localparam kind_type K_FMXR = 8'd95, K_FSUBS = 8'd96;
   localparam kind_type K_FMACD = 8'd97, K_FMDLR = 8'd98, K_FNMACD = 8'd99;
   localparam kind_type K_FDIVD = 8'd100, K_FMULD = 8'd101, K_FMDHR = 8'd102;
   localparam kind_type K_FNMULD = 8'd103, K_FMSCD = 8'd104, K_FMRDL = 8'd105;
   localparam kind_type K_FNMSCD = 8'd106, K_FLDD = 8'd107, K_FABSD = 8'd108;
   localparam kind_type K_FSQRTD = 8'd109, K_FCMPED = 8'd110, K_FCMPEZD = 8'd111;
   localparam kind_type K_FCVTSD = 8'd112, K_FCVTDS = 8'd113, K_FSITOD = 8'd114;
   localparam kind_type K_FTOUID = 8'd115, K_FTOSID = 8'd116, K_FCMPD = 8'd117;
   localparam kind_type K_FCMPZD = 8'd118, K_FCPYD = 8'd119, K_FNEGD = 8'd120;
   localparam kind_type K_FUITOD = 8'd121, K_FADDD = 8'd122, K_FMRDH = 8'd123;
   localparam kind_type K_FSUBD = 8'd124;
   localparam kind_type K_SSAT = 8'd125, K_USAT = 8'd126, K_PKHBT = 8'd127;
   localparam kind_type K_PKHTB = 8'd128, K_SEL = 8'd129, K_QADD16 = 8'd130;
   localparam kind_type K_QADD8 = 8'd131, K_QSUB16 = 8'd132, K_QSUB8 = 8'd133;
   localparam kind_type K_QSUBADDX = 8'd134, K_REV = 8'd135, K_REV16 = 8'd136;
   localparam kind_type K_SXTH = 8'd137, K_SXTAH = 8'd138, K_SSAT16 = 8'd139;
   localparam kind_type K_SXTB = 8'd140, K_SXTAB = 8'd141, K_SXTB16 = 8'd142;
   localparam kind_type K_SXTAB16 = 8'd143, K_UADDSUBX = 8'd144, K_UADD16 = 8'd145;
   localparam kind_type K_UADD8 = 8'd146, K_USUB16 = 8'd147, K_USUB8 = 8'd148;
   localparam kind_type K_USUBADDX = 8'd149, K_UQADD16 = 8'd150, K_UQADD8 = 8'd151;
   localparam kind_type K_REVSH = 8'd152, K_SADD16 = 8'd153, K_SADD8 = 8'd154;
   localparam kind_type K_SADDSUBX = 8'd155, K_SSUB16 = 8'd156, K_SSUB8 = 8'd157;
   localparam kind_type K_SSUBADDX = 8'd158, K_UQADDSUBX = 8'd159;
   localparam kind_type K_UQSUB16 = 8'd160, K_UQSUB8 = 8'd161, K_UQSUBADDX = 8'd162;
   localparam kind_type K_USAT16 = 8'd163, K_UXTB = 8'd164, K_UXTAB = 8'd165;
   localparam kind_type K_UXTB16 = 8'd166, K_UXTAB16 = 8'd167;
   localparam kind_type K_SHADD16 = 8'd168, K_SHADD8 = 8'd169, K_SHADDSUBX = 8'd170;
   localparam kind_type K_SHSUB16 = 8'd171, K_SHSUB8 = 8'd172, K_SHSUBADDX = 8'd173;
   localparam kind_type K_UHADD16 = 8'd174, K_UHADD8 = 8'd175, K_UHADDSUBX = 8'd176;
   localparam kind_type K_UHSUB16 = 8'd177, K_UHSUB8 = 8'd178, K_UHSUBADDX = 8'd179;
   localparam kind_type K_UXTH = 8'd180, K_UXTAH = 8'd181, K_SMUAD = 8'd182;
   localparam kind_type K_SMLAD = 8'd183, K_SMLALD = 8'd184, K_SMLSD = 8'd185;
   localparam kind_type K_SMUSD = 8'd186, K_SMLSLD = 8'd187, K_SMMUL = 8'd188;
   localparam kind_type K_SMMLA = 8'd189, K_SMMLS = 8'd190, K_USAD8 = 8'd191;
   localparam kind_type K_USADA8 = 8'd192, K_MCRR2 = 8'd193, K_MCRR = 8'd194;
   localparam kind_type K_FSTS = 8'd195, K_FSTMS = 8'd196, K_FSTD = 8'd197;
   localparam kind_type K_FSTMX = 8'd198, K_FSTMD = 8'd199, K_STC = 8'd200;
   localparam kind_type K_MRRC2 = 8'd201, K_MRRC = 8'd202, K_FLDS = 8'd203;
   localparam kind_type K_FLDMS = 8'd204, K_FLDMX = 8'd205, K_FLDMD = 8'd206;
   localparam kind_type K_LDC = 8'd207, K_CPY = 8'd208, K_MSR_IMM = 8'd209;
   localparam kind_type K_LDM1 = 8'd210, K_STM1 = 8'd211, K_STM2 = 8'd212;
   localparam kind_type K_LDM2 = 8'd213, K_LDM3 = 8'd214, K_BL = 8'd215, K_B = 8'd216;
   localparam kind_type K_SWI = 8'd217, K_MRC = 8'd218, K_MCR = 8'd219, K_CDP = 8'd220;

   // data processing: AND..RSC run 43..50, TST..CMNP interleave, ORR..MVN run 59..62
   function automatic kind_type alu_kind(input logic [3:0] op);
      kind_type k;
      if (op < 4'd8) k = K_AND + kind_type'(op);
      else if (op < 4'd12) k = K_TST + kind_type'({op[1:0], 1'b0});
      else k = K_ORR + kind_type'(op[1:0]);
      return k;
   endfunction

   function automatic kind_type dec_alu(input logic [31:0] w);
      kind_type k;
      if (w[24:23] != 2'b10 || w[20]) k = alu_kind(w[24:21]);
      else if (w[15:12] == 4'hF) k = K_TSTP + kind_type'({w[22:21], 1'b0});
      else k = K_UNDEF;
      return k;
   endfunction

   function automatic kind_type dec_misc(input logic [31:0] w);
      logic [4:0] hi;
      logic [3:0] lo;
      kind_type k;
      hi = w[24:20];
      lo = w[7:4];
      k = K_UNDEF;
      case (lo)
         4'h0: begin
            if (hi == 5'h10 || hi == 5'h14) k = K_MRS;
            if (hi == 5'h12 || hi == 5'h16) k = K_MSR_REG;
         end
         4'h1: begin
            if (hi == 5'h16) k = K_CLZ;
            if (hi == 5'h12) k = K_BX;
         end
         4'h3: if (hi == 5'h12) k = K_BLX2;
         4'h5: begin
            if (hi == 5'h10) k = K_QADD;
            if (hi == 5'h12) k = K_QSUB;
            if (hi == 5'h14) k = K_QDADD;
            if (hi == 5'h16) k = K_QDSUB;
         end
         4'h7: if (hi == Misc10 && w[31:28] == CondAlways) k = K_BKPT;
         4'h8, 4'hA, 4'hC, 4'hE: begin
            if (w[27:20] == 8'h10) k = K_SMLAXY;
            if (w[27:20] == 8'h14) k = K_SMLALXY;
            if (w[27:20] == 8'h16) k = K_SMULXY;
            if (w[27:20] == 8'h12) k = w[5] ? K_SMULWY : K_SMLAWY;
         end
         default: k = K_UNDEF;
      endcase
      return k;
   endfunction

   function automatic kind_type dec_mul(input logic [31:0] w);
      kind_type k;
      k = K_UNDEF;
      if (!w[20] && w[7:4] == 4'hF) k = K_STRD;
      else begin
         case (w[7:4])
            4'h9: begin
               case (w[24:20])
                  5'h00, 5'h01: k = K_MUL;
                  5'h02, 5'h03: k = K_MLA;
                  5'h04: k = K_UMAAL;
                  5'h08, 5'h09: k = K_UMULL;
                  5'h0A, 5'h0B: k = K_UMLAL;
                  5'h0C, 5'h0D: k = K_SMULL;
                  5'h0E, 5'h0F: k = K_SMLAL;
                  5'h10: k = K_SWP;
                  5'h14: k = K_SWPB;
                  5'h19: k = K_LDREX;
                  5'h18: k = K_STREX;
                  default: k = K_UNDEF;
               endcase
            end
            4'hB: k = w[20] ? K_LDRH : K_STRH;
            4'hD: k = w[20] ? K_LDRSB : K_LDRD;
            4'hF: k = K_LDRSH;
            default: k = K_UNDEF;
         endcase
      end
      return k;
   endfunction

   function automatic kind_type dec_uncond(input logic [31:0] w);
      kind_type k;
      k = K_UNDEF;
      if (!w[27]) begin
         if (w[26] && w[24] && w[22] && !w[21] && w[20] && w[15:12] == 4'hF) k = K_PLD;
         else if (w[26:20] == 7'b0010000 && !w[16] && !w[5]) k = K_CPS;
      end else begin
         case (w[26:25])
            2'd0: begin
               if (!w[22] && w[20] && w[11:8] == CpSingle) k = K_RFE;
               else if (w[22] && w[11:8] == 4'h5 && w[20:16] == 5'h0D) k = K_SRS;
            end
            2'd1: k = K_BLX1;
            2'd2: k = w[20] ? K_LDC2 : K_STC2;
            default: begin
               if (w[24]) k = K_UNDEF;
               else if (!w[4]) k = K_CDP2;
               else k = w[20] ? K_MRC2 : K_MCR2;
            end
         endcase
      end
      return k;
   endfunction

   function automatic kind_type dec_ldst(input logic [31:0] w);
      kind_type k;
      if (!w[24] && w[21]) k = K_STRT + kind_type'({w[22], w[20]});
      else k = K_STR + kind_type'({w[22], w[20]});
      return k;
   endfunction

   function automatic kind_type dec_vfps(input logic [31:0] w);
      logic [7:0] key;
      logic [3:0] mid;
      kind_type k;
      key = {w[24], w[23], w[21], w[20], w[7:4]};
      mid = w[19:16];
      k = K_UNDEF;
      case (key)
         8'h7C, 8'h7E: begin
            case (mid)
               4'h5: k = (key == 8'h7C) ? K_FCMPEZS : K_UNDEF;
               4'h4: k = K_FCMPES;
               4'h0: k = K_FABSS;
               4'h8: k = K_FSITOS;
               4'hD: k = K_FTOSIS;
               4'h1: k = K_FSQRTS;
               4'hC: k = K_FTOUIS;
               default: k = K_UNDEF;
            endcase
         end
         8'h74, 8'h76: begin
            case (mid)
               4'h4: k = K_FCMPS;
               4'h8: k = K_FUITOS;
               4'h5: k = K_FCMPZS;
               4'hD: k = K_FTOSIS;
               4'h0: k = K_FCPYS;
               4'h1: k = K_FNEGS;
               4'hC: k = K_FTOUIS;
               default: k = K_UNDEF;
            endcase
         end
         8'h30, 8'h32, 8'h38, 8'h3A: k = K_FADDS;
         8'h40, 8'h42, 8'h48, 8'h4A: k = K_FDIVS;
         8'h00, 8'h02, 8'h08, 8'h0A: k = K_FMACS;
         8'h04, 8'h06, 8'h0C, 8'h0E: k = K_FNMACS;
         8'h14, 8'h16, 8'h1C, 8'h1E: k = K_FNMSCS;
         8'h24, 8'h26, 8'h2C, 8'h2E: k = K_FNMULS;
         8'h10, 8'h12, 8'h18, 8'h1A: k = K_FMSCS;
         8'h20, 8'h22, 8'h28, 8'h2A: k = K_FMULS;
         8'h34, 8'h36, 8'h3C, 8'h3E: k = K_FSUBS;
         8'h11, 8'h19: if (!w[22]) k = K_FMRS;
         8'h71: if (w[22]) k = (w[19:12] == 8'h1F) ? K_FMSTAT : K_FMRX;
         8'h01, 8'h09: if (w[22]) k = K_FMSR;
         8'h61: if (w[22]) k = K_FMXR;
         default: k = K_UNDEF;
      endcase
      return k;
   endfunction

   function automatic kind_type dec_vfpd(input logic [31:0] w);
      logic [3:0] right, mid;
      logic       cpd;
      kind_type   k;
      right = w[7:4];
      mid = w[19:16];
      cpd = w[11:8] == CpDouble;
      k = K_UNDEF;
      case (w[23:20])
         4'h0: begin
            if (right == 4'h0) k = K_FMACD;
            if (right == 4'h1) k = K_FMDLR;
            if (right == 4'h4) k = K_FNMACD;
         end
         4'h8: if (right == 4'h0) k = K_FDIVD;
         4'h2: begin
            if (right == 4'h0) k = K_FMULD;
            if (right == 4'h1) k = K_FMDHR;
            if (right == 4'h4) k = K_FNMULD;
         end
         4'h1: begin
            if (right == 4'h0) k = K_FMSCD;
            else if (right == 4'h1) k = K_FMRDL;
            else if (right == 4'h4) k = K_FNMSCD;
            else if (cpd) k = K_FLDD;
         end
         4'h9: if (cpd) k = K_FLDD;
         4'hB: begin
            if (right == 4'hC) begin
               case (mid)
                  4'h0: k = K_FABSD;
                  4'h1: k = K_FSQRTD;
                  4'h4: k = K_FCMPED;
                  4'h5: k = K_FCMPEZD;
                  4'h7: begin
                     if (cpd) k = K_FCVTSD;
                     else if (w[11:8] == CpSingle) k = K_FCVTDS;
                  end
                  4'h8: k = K_FSITOD;
                  4'hC: k = K_FTOUID;
                  4'hD: k = K_FTOSID;
                  default: k = K_UNDEF;
               endcase
            end else if (right == 4'hE) begin
               if (mid == 4'h7) k = K_FCVTDS;
               if (mid == 4'h8) k = K_FSITOD;
            end else if (right == 4'h4) begin
               case (mid)
                  4'h4: k = K_FCMPD;
                  4'h5: k = K_FCMPZD;
                  4'h0: k = K_FCPYD;
                  4'h1: k = K_FNEGD;
                  4'hD: k = K_FTOSID;
                  4'hC: k = K_FTOUID;
                  4'h8: k = K_FUITOD;
                  default: k = K_UNDEF;
               endcase
            end else if (right == 4'h6 && mid == 4'h8) k = K_FUITOD;
         end
         4'h3: begin
            if (right == 4'h0) k = K_FADDD;
            if (right == 4'h1) k = K_FMRDH;
            if (right == 4'h4) k = K_FSUBD;
         end
         4'hF: begin
            if (right == 4'hC && mid == 4'h7) k = K_FCVTSD;
            else if (right == 4'hC || right == 4'h4) begin
               if (mid == 4'hD) k = K_FTOSID;
               if (mid == 4'hC) k = K_FTOUID;
            end
         end
         default: k = K_UNDEF;
      endcase
      return k;
   endfunction

   function automatic kind_type dec_media(input logic [31:0] w);
      logic rn15, ra15;
      kind_type k;
      rn15 = w[19:16] == 4'hF;
      ra15 = w[15:12] == 4'hF;
      k = K_UNDEF;
      if (!w[5] && w[24:21] == 4'h5) k = K_SSAT;
      else if (!w[5] && w[24:21] == 4'h7) k = K_USAT;
      else begin
         case ({w[24:20], w[7:4]})
            9'h089, 9'h081: k = K_PKHBT;
            9'h08D, 9'h085: k = K_PKHTB;
            9'h08B: k = K_SEL;
            9'h021: k = K_QADD16;
            9'h029, 9'h023: k = K_QADD8;
            9'h027: k = K_QSUB16;
            9'h02F: k = K_QSUB8;
            9'h025: k = K_QSUBADDX;
            9'h0B3: k = K_REV;
            9'h0BB: k = K_REV16;
            9'h0B7: k = rn15 ? K_SXTH : K_SXTAH;
            9'h0A3: k = K_SSAT16;
            9'h0A7: k = rn15 ? K_SXTB : K_SXTAB;
            9'h087: k = rn15 ? K_SXTB16 : K_SXTAB16;
            9'h053: k = K_UADDSUBX;
            9'h051: k = K_UADD16;
            9'h059: k = K_UADD8;
            9'h057: k = K_USUB16;
            9'h05F: k = K_USUB8;
            9'h055: k = K_USUBADDX;
            9'h061: k = K_UQADD16;
            9'h069: k = K_UQADD8;
            9'h0FB: k = K_REVSH;
            9'h011: k = K_SADD16;
            9'h019: k = K_SADD8;
            9'h013: k = K_SADDSUBX;
            9'h017: k = K_SSUB16;
            9'h01F: k = K_SSUB8;
            9'h015: k = K_SSUBADDX;
            9'h063: k = K_UQADDSUBX;
            9'h067: k = K_UQSUB16;
            9'h06F: k = K_UQSUB8;
            9'h065: k = K_UQSUBADDX;
            9'h0E3: k = K_USAT16;
            9'h0E7: k = rn15 ? K_UXTB : K_UXTAB;
            9'h0C7: k = rn15 ? K_UXTB16 : K_UXTAB16;
            9'h031: k = K_SHADD16;
            9'h039: k = K_SHADD8;
            9'h033: k = K_SHADDSUBX;
            9'h037: k = K_SHSUB16;
            9'h03F: k = K_SHSUB8;
            9'h035: k = K_SHSUBADDX;
            9'h071: k = K_UHADD16;
            9'h079: k = K_UHADD8;
            9'h073: k = K_UHADDSUBX;
            9'h077: k = K_UHSUB16;
            9'h07F: k = K_UHSUB8;
            9'h075: k = K_UHSUBADDX;
            9'h0F7: k = rn15 ? K_UXTH : K_UXTAH;
            9'h101, 9'h103: k = ra15 ? K_SMUAD : K_SMLAD;
            9'h141, 9'h143: k = K_SMLALD;
            9'h105, 9'h107: k = ra15 ? K_SMUSD : K_SMLSD;
            9'h145, 9'h147: k = K_SMLSLD;
            9'h151, 9'h153: k = ra15 ? K_SMMUL : K_SMMLA;
            9'h15D, 9'h15F: k = K_SMMLS;
            9'h181: k = ra15 ? K_USAD8 : K_USADA8;
            default: k = K_UNDEF;
         endcase
      end
      return k;
   endfunction

   function automatic kind_type dec_copro(input logic [31:0] w);
      logic [4:0] hi;
      logic       nv;
      kind_type   k;
      hi = w[24:20];
      nv = w[31:28] == CondNever;
      if (!w[20]) begin
         if (hi == 5'h04) k = nv ? K_MCRR2 : K_MCRR;
         else if (w[11:8] == CpSingle) k = (w[24] && !w[21]) ? K_FSTS : K_FSTMS;
         else if (w[11:8] == CpDouble && !w[22]) begin
            if (w[24] && !w[21]) k = K_FSTD;
            else k = w[0] ? K_FSTMX : K_FSTMD;
         end else k = K_STC;
      end else begin
         if (hi == 5'h05) k = nv ? K_MRRC2 : K_MRRC;
         else if (w[11:8] == CpSingle) k = (w[24] && !w[21]) ? K_FLDS : K_FLDMS;
         else if (w[11:8] == CpDouble && !w[22]) k = w[0] ? K_FLDMX : K_FLDMD;
         else k = K_LDC;
      end
      return k;
   endfunction

   function automatic kind_type classify(input logic [31:0] w);
      logic     nv;
      kind_type uk, k;
      nv = w[31:28] == CondNever;
      uk = nv ? dec_uncond(w) : K_UNDEF;
      k = K_UNDEF;
      case (w[27:25])
         3'd0: begin
            if (w[4] && w[7]) k = dec_mul(w);
            else if (w[24] && !w[23] && !w[20]) k = dec_misc(w);
            else if (!w[4] && w[27:20] == CpyTop && w[11:4] == 8'h00) k = K_CPY;
            else k = dec_alu(w);
         end
         3'd1: begin
            case ({w[24], w[23], w[21], w[20]})
               4'h8: k = K_UNDEF;
               4'hA: k = K_MSR_IMM;
               default: k = dec_alu(w);
            endcase
         end
         3'd2: k = dec_ldst(w);
         3'd3: k = w[4] ? dec_media(w) : dec_ldst(w);
         3'd4: begin
            if (nv) k = K_UNDEF;
            else if (!w[22]) k = w[20] ? K_LDM1 : K_STM1;
            else if (!w[21] && !w[20]) k = K_STM2;
            else if (!w[21] && w[20] && !w[15]) k = K_LDM2;
            else if (w[20] && w[15]) k = K_LDM3;
         end
         3'd5: k = w[24] ? K_BL : K_B;
         3'd6: k = dec_copro(w);
         default: begin
            if (w[24]) k = nv ? K_UNDEF : K_SWI;
            else if (w[4]) k = w[20] ? K_MRC : K_MCR;
            else if (w[11:8] == CpSingle) k = dec_vfps(w);
            else if (w[11:8] == CpDouble) k = dec_vfpd(w);
            else k = K_CDP;
         end
      endcase
      return (uk != K_UNDEF) ? uk : k;
   endfunction

endpackage

### rtl/core/aic_if.sv
interface aic_req_if;
   logic                           valid;
   logic                           ready;
   logic [aic_pkg::WordWidth-1:0] instr_word;
   modport source (output valid, output instr_word, input ready);
   modport sink (input valid, input instr_word, output ready);
endinterface

interface aic_rsp_if;
   logic               valid;
   logic               ready;
   aic_pkg::kind_type instr_kind;
   logic               is_undefined;
   modport source (output valid, output instr_kind, output is_undefined, input ready);
   modport sink (input valid, input instr_kind, input is_undefined, output ready);
endinterface

### rtl/core/arm_instruction_classifier_top.sv
// Classifies one 32-bit ARM (v5/v6 + VFP) instruction word per cycle, as long as
// the output buffer has room, into a dense instruction identifier, 0 meaning
// undefined. The word is registered, decoded by one flat pass of combinational
// logic, and the result registered into a two-entry output buffer; the request side
// stalls while the input register is loaded and the buffer's second entry is full.
module arm_instruction_classifier_top (
   input logic clock,
   input logic reset,
   aic_req_if.sink req,
   aic_rsp_if.source rsp
);

   logic                           in_vld_ff, in_vld_in;
   logic [aic_pkg::WordWidth-1:0] word_ff;
   aic_pkg::kind_type              kind;

   logic [1:0]        q_vld_ff, q_vld_in;
   aic_pkg::kind_type q_kind_ff [2];
   logic              push, pop, accept;

   assign kind = aic_pkg::classify(word_ff);

   // new words wait while the input register is loaded and the buffer is full
   assign req.ready = !(in_vld_ff && q_vld_ff[1]);
   assign accept = req.valid && req.ready;
   assign push = in_vld_ff && (!q_vld_ff[1] || pop);
   assign in_vld_in = accept || (in_vld_ff && !push);
   assign pop = rsp.valid && rsp.ready;

   always_comb begin
      q_vld_in = q_vld_ff;
      if (pop) q_vld_in = {1'b0, q_vld_ff[1]};
      if (push) begin
         if (q_vld_in[0]) q_vld_in[1] = 1'b1;
         else q_vld_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         q_vld_ff <= 2'b00;
      end else begin
         in_vld_ff <= in_vld_in;
         q_vld_ff <= q_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) word_ff <= req.instr_word;
      if (pop) q_kind_ff[0] <= q_kind_ff[1];
      if (push) begin
         if ((pop ? q_vld_ff[1] : q_vld_ff[0])) q_kind_ff[1] <= kind;
         else q_kind_ff[0] <= kind;
      end
   end

   assign rsp.valid = q_vld_ff[0];
   assign rsp.instr_kind = q_kind_ff[0];
   assign rsp.is_undefined = q_kind_ff[0] == aic_pkg::K_UNDEF;

endmodule

### rtl/core/aic_checker.sv
module aic_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input aic_pkg::kind_type rsp_instr_kind,
   input logic              rsp_is_undefined
);

   a_undef_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_undefined == (rsp_instr_kind == aic_pkg::K_UNDEF)))
      else $error("undefined flag disagrees with kind");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_instr_kind))
      else $error("stalled response changed");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("accepted request gave no response");

   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |=> req_ready)
      else $error("request side blocked with free output");

endmodule

bind arm_instruction_classifier_top aic_checker u_aic_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_instr_kind(rsp.instr_kind),
   .rsp_is_undefined(rsp.is_undefined)
);

### verif/arm_instruction_classifier_top_tb.sv
module arm_instruction_classifier_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned StallLimit = 5000;

   logic clock;
   logic reset;

   aic_req_if req_ch ();
   aic_rsp_if rsp_ch ();

   arm_instruction_classifier_top i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   aic_pkg::kind_type pending_kinds[$];
   int unsigned       error_count;
   int unsigned       stall_cycles;
   int unsigned       hold_cycles;
   bit                quiet;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // data processing identifiers follow opcode order, TST..CMN spaced by their P forms
   function automatic aic_pkg::kind_type alu_op_kind(input logic [3:0] op);
      aic_pkg::kind_type k;
      if (op < 4'd8) k = aic_pkg::K_AND + aic_pkg::kind_type'(op);
      else if (op < 4'd12) k = aic_pkg::K_TST + aic_pkg::kind_type'(2 * (op - 4'd8));
      else k = aic_pkg::K_ORR + aic_pkg::kind_type'(op - 4'd12);
      return k;
   endfunction

   function automatic aic_pkg::kind_type pred_alu(input logic [31:0] w);
      aic_pkg::kind_type k;
      if (w[24:21] < 4'd8 || w[24:21] > 4'd11 || w[20]) k = alu_op_kind(w[24:21]);
      else if (w[15:12] == 4'hF) k = aic_pkg::K_TSTP + aic_pkg::kind_type'(2 * w[22:21]);
      else k = aic_pkg::K_UNDEF;
      return k;
   endfunction

   function automatic aic_pkg::kind_type pred_misc(input logic [31:0] w);
      logic [4:0]        hi;
      logic [3:0]        lo;
      aic_pkg::kind_type k;
      hi = w[24:20];
      lo = w[7:4];
      k = aic_pkg::K_UNDEF;
      case (lo)
         4'h0: begin
            if (hi == 5'h10 || hi == 5'h14) k = aic_pkg::K_MRS;
            else if (hi == 5'h12 || hi == 5'h16) k = aic_pkg::K_MSR_REG;
         end
         4'h1: begin
            if (hi == 5'h16) k = aic_pkg::K_CLZ;
            else if (hi == 5'h12) k = aic_pkg::K_BX;
         end
         4'h3: if (hi == 5'h12) k = aic_pkg::K_BLX2;
         4'h5: begin
            case (hi)
               5'h10: k = aic_pkg::K_QADD;
               5'h12: k = aic_pkg::K_QSUB;
               5'h14: k = aic_pkg::K_QDADD;
               5'h16: k = aic_pkg::K_QDSUB;
               default: k = aic_pkg::K_UNDEF;
            endcase
         end
         4'h7: if (hi == 5'h12 && w[31:28] == 4'hE) k = aic_pkg::K_BKPT;
         4'h8, 4'hA, 4'hC, 4'hE: begin
            case (w[27:20])
               8'h10: k = aic_pkg::K_SMLAXY;
               8'h14: k = aic_pkg::K_SMLALXY;
               8'h16: k = aic_pkg::K_SMULXY;
               8'h12: k = (lo == 4'h8 || lo == 4'hC) ? aic_pkg::K_SMLAWY : aic_pkg::K_SMULWY;
               default: k = aic_pkg::K_UNDEF;
            endcase
         end
         default: k = aic_pkg::K_UNDEF;
      endcase
      return k;
   endfunction

   function automatic aic_pkg::kind_type pred_mul(input logic [31:0] w);
      aic_pkg::kind_type k;
      k = aic_pkg::K_UNDEF;
      if (!w[20] && w[7:4] == 4'hF) k = aic_pkg::K_STRD;
      else begin
         case (w[7:4])
            4'h9: begin
               case (w[24:20])
                  5'h00, 5'h01: k = aic_pkg::K_MUL;
                  5'h02, 5'h03: k = aic_pkg::K_MLA;
                  5'h04: k = aic_pkg::K_UMAAL;
                  5'h08, 5'h09: k = aic_pkg::K_UMULL;
                  5'h0A, 5'h0B: k = aic_pkg::K_UMLAL;
                  5'h0C, 5'h0D: k = aic_pkg::K_SMULL;
                  5'h0E, 5'h0F: k = aic_pkg::K_SMLAL;
                  5'h10: k = aic_pkg::K_SWP;
                  5'h14: k = aic_pkg::K_SWPB;
                  5'h19: k = aic_pkg::K_LDREX;
                  5'h18: k = aic_pkg::K_STREX;
                  default: k = aic_pkg::K_UNDEF;
               endcase
            end
            4'hB: k = w[20] ? aic_pkg::K_LDRH : aic_pkg::K_STRH;
            4'hD: k = w[20] ? aic_pkg::K_LDRSB : aic_pkg::K_LDRD;
            4'hF: k = aic_pkg::K_LDRSH;
            default: k = aic_pkg::K_UNDEF;
         endcase
      end
      return k;
   endfunction

   function automatic aic_pkg::kind_type pred_uncond(input logic [31:0] w);
      aic_pkg::kind_type k;
      k = aic_pkg::K_UNDEF;
      if (!w[27]) begin
         if (w[26] && w[24] && w[22] && !w[21] && w[20] && w[15:12] == 4'hF)
            k = aic_pkg::K_PLD;
         else if (w[26:20] == 7'b0010000 && !w[16] && !w[5]) k = aic_pkg::K_CPS;
      end else begin
         case (w[26:25])
            2'd0: begin
               if (!w[22] && w[20] && w[11:8] == 4'hA) k = aic_pkg::K_RFE;
               else if (w[22] && w[11:8] == 4'h5 && w[20:16] == 5'h0D) k = aic_pkg::K_SRS;
            end
            2'd1: k = aic_pkg::K_BLX1;
            2'd2: k = w[20] ? aic_pkg::K_LDC2 : aic_pkg::K_STC2;
            default: begin
               if (w[24]) k = aic_pkg::K_UNDEF;
               else if (!w[4]) k = aic_pkg::K_CDP2;
               else k = w[20] ? aic_pkg::K_MRC2 : aic_pkg::K_MCR2;
            end
         endcase
      end
      return k;
   endfunction

   function automatic aic_pkg::kind_type pred_ldst(input logic [31:0] w);
      aic_pkg::kind_type k;
      if (!w[24] && w[21])
         k = w[22] ? (w[20] ? aic_pkg::K_LDRBT : aic_pkg::K_STRBT)
                   : (w[20] ? aic_pkg::K_LDRT : aic_pkg::K_STRT);
      else
         k = w[22] ? (w[20] ? aic_pkg::K_LDRB : aic_pkg::K_STRB)
                   : (w[20] ? aic_pkg::K_LDR : aic_pkg::K_STR);
      return k;
   endfunction

   function automatic aic_pkg::kind_type pred_vfp_single(input logic [31:0] w);
      logic [7:0]        key;
      logic [3:0]        mid;
      aic_pkg::kind_type k;
      key = {w[24], w[23], w[21], w[20], w[7:4]};
      mid = w[19:16];
      k = aic_pkg::K_UNDEF;
      case (key)
         8'h7C, 8'h7E: begin
            // compare with zero exists only in the 7c form
            if (key == 8'h7C && mid == 4'h5) k = aic_pkg::K_FCMPEZS;
            else begin
               case (mid)
                  4'h4: k = aic_pkg::K_FCMPES;
                  4'h0: k = aic_pkg::K_FABSS;
                  4'h8: k = aic_pkg::K_FSITOS;
                  4'hD: k = aic_pkg::K_FTOSIS;
                  4'h1: k = aic_pkg::K_FSQRTS;
                  4'hC: k = aic_pkg::K_FTOUIS;
                  default: k = aic_pkg::K_UNDEF;
               endcase
            end
         end
         8'h74, 8'h76: begin
            case (mid)
               4'h4: k = aic_pkg::K_FCMPS;
               4'h8: k = aic_pkg::K_FUITOS;
               4'h5: k = aic_pkg::K_FCMPZS;
               4'hD: k = aic_pkg::K_FTOSIS;
               4'h0: k = aic_pkg::K_FCPYS;
               4'h1: k = aic_pkg::K_FNEGS;
               4'hC: k = aic_pkg::K_FTOUIS;
               default: k = aic_pkg::K_UNDEF;
            endcase
         end
         8'h30, 8'h32, 8'h38, 8'h3A: k = aic_pkg::K_FADDS;
         8'h40, 8'h42, 8'h48, 8'h4A: k = aic_pkg::K_FDIVS;
         8'h00, 8'h02, 8'h08, 8'h0A: k = aic_pkg::K_FMACS;
         8'h04, 8'h06, 8'h0C, 8'h0E: k = aic_pkg::K_FNMACS;
         8'h14, 8'h16, 8'h1C, 8'h1E: k = aic_pkg::K_FNMSCS;
         8'h24, 8'h26, 8'h2C, 8'h2E: k = aic_pkg::K_FNMULS;
         8'h10, 8'h12, 8'h18, 8'h1A: k = aic_pkg::K_FMSCS;
         8'h20, 8'h22, 8'h28, 8'h2A: k = aic_pkg::K_FMULS;
         8'h34, 8'h36, 8'h3C, 8'h3E: k = aic_pkg::K_FSUBS;
         8'h11, 8'h19: if (!w[22]) k = aic_pkg::K_FMRS;
         8'h71: begin
            if (w[22])
               k = (w[19:12] == 8'h1F && w[4]) ? aic_pkg::K_FMSTAT : aic_pkg::K_FMRX;
         end
         8'h01, 8'h09: if (w[22]) k = aic_pkg::K_FMSR;
         8'h61: if (w[22]) k = aic_pkg::K_FMXR;
         default: k = aic_pkg::K_UNDEF;
      endcase
      return k;
   endfunction

   function automatic aic_pkg::kind_type pred_vfp_double(input logic [31:0] w);
      logic [3:0]        right, mid, cp;
      aic_pkg::kind_type k;
      right = w[7:4];
      mid = w[19:16];
      cp = w[11:8];
      k = aic_pkg::K_UNDEF;
      case (w[23:20])
         4'h0: begin
            if (right == 4'h0) k = aic_pkg::K_FMACD;
            else if (right == 4'h1) k = aic_pkg::K_FMDLR;
            else if (right == 4'h4) k = aic_pkg::K_FNMACD;
         end
         4'h8: if (right == 4'h0) k = aic_pkg::K_FDIVD;
         4'h2: begin
            if (right == 4'h0) k = aic_pkg::K_FMULD;
            else if (right == 4'h1) k = aic_pkg::K_FMDHR;
            else if (right == 4'h4) k = aic_pkg::K_FNMULD;
         end
         4'h1: begin
            if (right == 4'h0) k = aic_pkg::K_FMSCD;
            else if (right == 4'h1) k = aic_pkg::K_FMRDL;
            else if (right == 4'h4) k = aic_pkg::K_FNMSCD;
            else if (cp == 4'hB) k = aic_pkg::K_FLDD;
         end
         4'h9: if (cp == 4'hB) k = aic_pkg::K_FLDD;
         4'hB: begin
            if (right == 4'hC) begin
               case (mid)
                  4'h0: k = aic_pkg::K_FABSD;
                  4'h1: k = aic_pkg::K_FSQRTD;
                  4'h4: k = aic_pkg::K_FCMPED;
                  4'h5: k = aic_pkg::K_FCMPEZD;
                  4'h7: begin
                     if (cp == 4'hB) k = aic_pkg::K_FCVTSD;
                     else if (cp == 4'hA) k = aic_pkg::K_FCVTDS;
                     else k = aic_pkg::K_UNDEF;
                  end
                  4'h8: k = aic_pkg::K_FSITOD;
                  4'hC: k = aic_pkg::K_FTOUID;
                  4'hD: k = aic_pkg::K_FTOSID;
                  default: k = aic_pkg::K_UNDEF;
               endcase
            end else if (right == 4'hE) begin
               if (mid == 4'h7) k = aic_pkg::K_FCVTDS;
               else if (mid == 4'h8) k = aic_pkg::K_FSITOD;
            end else if (right == 4'h4) begin
               case (mid)
                  4'h4: k = aic_pkg::K_FCMPD;
                  4'h5: k = aic_pkg::K_FCMPZD;
                  4'h0: k = aic_pkg::K_FCPYD;
                  4'h1: k = aic_pkg::K_FNEGD;
                  4'hD: k = aic_pkg::K_FTOSID;
                  4'hC: k = aic_pkg::K_FTOUID;
                  4'h8: k = aic_pkg::K_FUITOD;
                  default: k = aic_pkg::K_UNDEF;
               endcase
            end else if (right == 4'h6 && mid == 4'h8) k = aic_pkg::K_FUITOD;
         end
         4'h3: begin
            if (right == 4'h0) k = aic_pkg::K_FADDD;
            else if (right == 4'h1) k = aic_pkg::K_FMRDH;
            else if (right == 4'h4) k = aic_pkg::K_FSUBD;
         end
         4'hF: begin
            if (right == 4'hC && mid == 4'h7) k = aic_pkg::K_FCVTSD;
            else if (right == 4'hC || right == 4'h4) begin
               if (mid == 4'hD) k = aic_pkg::K_FTOSID;
               else if (mid == 4'hC) k = aic_pkg::K_FTOUID;
            end
         end
         default: k = aic_pkg::K_UNDEF;
      endcase
      return k;
   endfunction

   function automatic aic_pkg::kind_type pred_media(input logic [31:0] w);
      logic              rn15, ra15;
      aic_pkg::kind_type k;
      rn15 = w[19:16] == 4'hF;
      ra15 = w[15:12] == 4'hF;
      if (!w[5] && w[24:21] == 4'h5) k = aic_pkg::K_SSAT;
      else if (!w[5] && w[24:21] == 4'h7) k = aic_pkg::K_USAT;
      else begin
         case ({w[24:20], w[7:4]})
            {5'h08, 4'h9}, {5'h08, 4'h1}: k = aic_pkg::K_PKHBT;
            {5'h08, 4'hD}, {5'h08, 4'h5}: k = aic_pkg::K_PKHTB;
            {5'h08, 4'hB}: k = aic_pkg::K_SEL;
            {5'h02, 4'h1}: k = aic_pkg::K_QADD16;
            {5'h02, 4'h9}, {5'h02, 4'h3}: k = aic_pkg::K_QADD8;
            {5'h02, 4'h7}: k = aic_pkg::K_QSUB16;
            {5'h02, 4'hF}: k = aic_pkg::K_QSUB8;
            {5'h02, 4'h5}: k = aic_pkg::K_QSUBADDX;
            {5'h0B, 4'h3}: k = aic_pkg::K_REV;
            {5'h0B, 4'hB}: k = aic_pkg::K_REV16;
            {5'h0B, 4'h7}: k = rn15 ? aic_pkg::K_SXTH : aic_pkg::K_SXTAH;
            {5'h0A, 4'h3}: k = aic_pkg::K_SSAT16;
            {5'h0A, 4'h7}: k = rn15 ? aic_pkg::K_SXTB : aic_pkg::K_SXTAB;
            {5'h08, 4'h7}: k = rn15 ? aic_pkg::K_SXTB16 : aic_pkg::K_SXTAB16;
            {5'h05, 4'h3}: k = aic_pkg::K_UADDSUBX;
            {5'h05, 4'h1}: k = aic_pkg::K_UADD16;
            {5'h05, 4'h9}: k = aic_pkg::K_UADD8;
            {5'h05, 4'h7}: k = aic_pkg::K_USUB16;
            {5'h05, 4'hF}: k = aic_pkg::K_USUB8;
            {5'h05, 4'h5}: k = aic_pkg::K_USUBADDX;
            {5'h06, 4'h1}: k = aic_pkg::K_UQADD16;
            {5'h06, 4'h9}: k = aic_pkg::K_UQADD8;
            {5'h0F, 4'hB}: k = aic_pkg::K_REVSH;
            {5'h01, 4'h1}: k = aic_pkg::K_SADD16;
            {5'h01, 4'h9}: k = aic_pkg::K_SADD8;
            {5'h01, 4'h3}: k = aic_pkg::K_SADDSUBX;
            {5'h01, 4'h7}: k = aic_pkg::K_SSUB16;
            {5'h01, 4'hF}: k = aic_pkg::K_SSUB8;
            {5'h01, 4'h5}: k = aic_pkg::K_SSUBADDX;
            {5'h06, 4'h3}: k = aic_pkg::K_UQADDSUBX;
            {5'h06, 4'h7}: k = aic_pkg::K_UQSUB16;
            {5'h06, 4'hF}: k = aic_pkg::K_UQSUB8;
            {5'h06, 4'h5}: k = aic_pkg::K_UQSUBADDX;
            {5'h0E, 4'h3}: k = aic_pkg::K_USAT16;
            {5'h0E, 4'h7}: k = rn15 ? aic_pkg::K_UXTB : aic_pkg::K_UXTAB;
            {5'h0C, 4'h7}: k = rn15 ? aic_pkg::K_UXTB16 : aic_pkg::K_UXTAB16;
            {5'h03, 4'h1}: k = aic_pkg::K_SHADD16;
            {5'h03, 4'h9}: k = aic_pkg::K_SHADD8;
            {5'h03, 4'h3}: k = aic_pkg::K_SHADDSUBX;
            {5'h03, 4'h7}: k = aic_pkg::K_SHSUB16;
            {5'h03, 4'hF}: k = aic_pkg::K_SHSUB8;
            {5'h03, 4'h5}: k = aic_pkg::K_SHSUBADDX;
            {5'h07, 4'h1}: k = aic_pkg::K_UHADD16;
            {5'h07, 4'h9}: k = aic_pkg::K_UHADD8;
            {5'h07, 4'h3}: k = aic_pkg::K_UHADDSUBX;
            {5'h07, 4'h7}: k = aic_pkg::K_UHSUB16;
            {5'h07, 4'hF}: k = aic_pkg::K_UHSUB8;
            {5'h07, 4'h5}: k = aic_pkg::K_UHSUBADDX;
            {5'h0F, 4'h7}: k = rn15 ? aic_pkg::K_UXTH : aic_pkg::K_UXTAH;
            {5'h10, 4'h1}, {5'h10, 4'h3}: k = ra15 ? aic_pkg::K_SMUAD : aic_pkg::K_SMLAD;
            {5'h14, 4'h1}, {5'h14, 4'h3}: k = aic_pkg::K_SMLALD;
            {5'h10, 4'h5}, {5'h10, 4'h7}: k = ra15 ? aic_pkg::K_SMUSD : aic_pkg::K_SMLSD;
            {5'h14, 4'h5}, {5'h14, 4'h7}: k = aic_pkg::K_SMLSLD;
            {5'h15, 4'h1}, {5'h15, 4'h3}: k = ra15 ? aic_pkg::K_SMMUL : aic_pkg::K_SMMLA;
            {5'h15, 4'hD}, {5'h15, 4'hF}: k = aic_pkg::K_SMMLS;
            {5'h18, 4'h1}: k = ra15 ? aic_pkg::K_USAD8 : aic_pkg::K_USADA8;
            default: k = aic_pkg::K_UNDEF;
         endcase
      end
      return k;
   endfunction

   function automatic aic_pkg::kind_type pred_copro(input logic [31:0] w);
      logic [4:0]        hi;
      logic              nv;
      aic_pkg::kind_type k;
      hi = w[24:20];
      nv = w[31:28] == 4'hF;
      if (!w[20]) begin
         if (hi == 5'h04) k = nv ? aic_pkg::K_MCRR2 : aic_pkg::K_MCRR;
         else if (w[11:8] == 4'hA)
            k = (w[24] && !w[21]) ? aic_pkg::K_FSTS : aic_pkg::K_FSTMS;
         else if (w[11:8] == 4'hB && !w[22]) begin
            if (w[24] && !w[21]) k = aic_pkg::K_FSTD;
            else k = w[0] ? aic_pkg::K_FSTMX : aic_pkg::K_FSTMD;
         end else k = aic_pkg::K_STC;
      end else begin
         if (hi == 5'h05) k = nv ? aic_pkg::K_MRRC2 : aic_pkg::K_MRRC;
         else if (w[11:8] == 4'hA)
            k = (hi == 5'h11 || hi == 5'h15 || hi == 5'h19 || hi == 5'h1D)
                ? aic_pkg::K_FLDS : aic_pkg::K_FLDMS;
         else if (w[11:8] == 4'hB && !w[22]) k = w[0] ? aic_pkg::K_FLDMX : aic_pkg::K_FLDMD;
         else k = aic_pkg::K_LDC;
      end
      return k;
   endfunction

   function automatic aic_pkg::kind_type predict_kind(input logic [31:0] w);
      logic              nv;
      aic_pkg::kind_type k;
      nv = w[31:28] == 4'hF;
      k = nv ? pred_uncond(w) : aic_pkg::K_UNDEF;
      if (k == aic_pkg::K_UNDEF) begin
         case (w[27:25])
            3'd0: begin
               if (w[4] && w[7]) k = pred_mul(w);
               else if (w[24] && !w[23] && !w[20]) k = pred_misc(w);
               else if (!w[4] && w[27:20] == 8'h1A && w[11:4] == 8'h00) k = aic_pkg::K_CPY;
               else k = pred_alu(w);
            end
            3'd1: begin
               if ({w[24], w[23], w[21], w[20]} == 4'h8) k = aic_pkg::K_UNDEF;
               else if ({w[24], w[23], w[21], w[20]} == 4'hA) k = aic_pkg::K_MSR_IMM;
               else k = pred_alu(w);
            end
            3'd2: k = pred_ldst(w);
            3'd3: k = w[4] ? pred_media(w) : pred_ldst(w);
            3'd4: begin
               if (nv) k = aic_pkg::K_UNDEF;
               else if (!w[22]) k = w[20] ? aic_pkg::K_LDM1 : aic_pkg::K_STM1;
               else if (!w[21] && !w[20]) k = aic_pkg::K_STM2;
               else if (!w[21] && w[20] && !w[15]) k = aic_pkg::K_LDM2;
               else if (w[20] && w[15]) k = aic_pkg::K_LDM3;
               else k = aic_pkg::K_UNDEF;
            end
            3'd5: k = w[24] ? aic_pkg::K_BL : aic_pkg::K_B;
            3'd6: k = pred_copro(w);
            default: begin
               if (w[24]) k = nv ? aic_pkg::K_UNDEF : aic_pkg::K_SWI;
               else if (w[4]) k = w[20] ? aic_pkg::K_MRC : aic_pkg::K_MCR;
               else if (w[11:8] == 4'hA) k = pred_vfp_single(w);
               else if (w[11:8] == 4'hB) k = pred_vfp_double(w);
               else k = aic_pkg::K_CDP;
            end
         endcase
      end
      return k;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // request side: valid stays high between back-to-back requests
   task automatic send_word(input logic [31:0] w);
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.instr_word = w;
      do @(posedge clock); while (!req_ch.ready);
      pending_kinds.push_back(predict_kind(w));
   endtask

   task automatic idle_sender(input int unsigned n);
      @(negedge clock);
      req_ch.valid = 1'b0;
      req_ch.instr_word = $urandom;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 14));
   endtask

   function automatic logic [31:0] shaped_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 3))
         0: w[31:28] = 4'hF;
         1: w[31:28] = 4'hE;
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: w[11:8] = 4'hA;
         1: w[11:8] = 4'hB;
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0) w[19:16] = 4'hF;
      if ($urandom_range(0, 3) == 0) w[15:12] = 4'hF;
      case ($urandom_range(0, 4))
         // media: odd low nibble, small op field
         0: begin
            w[27:25] = 3'b011;
            w[4] = 1'b1;
            w[24:20] = 5'($urandom_range(0, 24));
         end
         // multiplies and extra loads
         1: begin
            w[27:25] = 3'b000;
            w[7] = 1'b1;
            w[4] = 1'b1;
         end
         // misc group
         2: begin
            w[27:25] = 3'b000;
            w[24:23] = 2'b10;
            w[20] = 1'b0;
            w[7] = $urandom_range(0, 1) ? 1'b0 : w[7];
         end
         // coprocessor and vfp data
         3: w[27:26] = 2'b11;
         default: ;
      endcase
      return w;
   endfunction

   task automatic test_directed();
      logic [31:0] words[$];
      words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hE1A0_0000, 32'hE1A0_1002,
                32'hF5D0_F000, 32'hF100_0000, 32'hF101_0000, 32'hF810_0A00,
                32'hE120_0070, 32'h0120_0070, 32'hE4A0_0000, 32'hE4F0_0000,
                32'hE6A0_0010, 32'hE6E0_0010, 32'hE700_F050, 32'hE700_0050,
                32'hE740_0050, 32'hE620_0030, 32'hE630_0090, 32'hF800_0000,
                32'hFF00_0000, 32'hEF00_0000, 32'hEEB0_0AC0, 32'hEEF1_FA10,
                32'hED90_0A00};
      foreach (words[i]) begin
         send_word(words[i]);
         maybe_gap();
      end
   endtask

   task automatic test_random_mix(input int unsigned n);
      repeat (n) begin
         send_word(($urandom_range(0, 4) == 0) ? 32'($urandom) : shaped_word());
         maybe_gap();
      end
   endtask

   task automatic test_output_stall();
      hold_cycles = 120;
      repeat (40) send_word(shaped_word());
   endtask

   task automatic test_drain_pause();
      test_random_mix(40);
      idle_sender(1);
      while (pending_kinds.size() != 0) @(posedge clock);
      test_random_mix(40);
   endtask

   task automatic test_quiet_stream(input int unsigned n);
      quiet = 1'b1;
      repeat (n) send_word(shaped_word());
      idle_sender(1);
   endtask

   // response side: random stalls, plus a long hold when asked
   initial begin
      int unsigned burst;
      burst = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            hold_cycles--;
            rsp_ch.ready = 1'b0;
         end else if (burst != 0) begin
            burst--;
            rsp_ch.ready = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(0, 13);
            rsp_ch.ready = 1'b0;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      aic_pkg::kind_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_kinds.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending, kind %0d",
                                      rsp_ch.instr_kind));
         end else begin
            want = pending_kinds.pop_front();
            if (rsp_ch.instr_kind !== want)
               report_mismatch($sformatf("instr_kind %0d, predicted %0d",
                                         rsp_ch.instr_kind, want));
            if (rsp_ch.is_undefined !== (want == aic_pkg::K_UNDEF))
               report_mismatch($sformatf("is_undefined %b for kind %0d",
                                         rsp_ch.is_undefined, want));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (!req_ch.valid && pending_kinds.size() == 0))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= StallLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      stall_cycles = 0;
      hold_cycles = 0;
      quiet = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.instr_word = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_mix(700);
      test_output_stall();
      test_drain_pause();
      test_random_mix(700);
      test_quiet_stream(200);

      while (pending_kinds.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
